// ===== hw/rtl/cssr_pkg.sv =====
`default_nettype none

package cssr_pkg;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int PID_W    = 3;
  localparam int SLOT_W   = 3;
  localparam int SWAP_W   = 2;
  localparam int STATUS_W = 2;

  // Default sizes
  localparam int DEF_RESIDENT_SLOTS = 5;
  localparam int DEF_SWAP_SLOTS     = 3;
  localparam int DEF_PROCESS_IDS    = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_MARK   = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_SWAP   = 2'd3
  } cmd_t;

  localparam logic [STATUS_W-1:0] STS_DONE = 2'd0;  // done / found resident
  localparam logic [STATUS_W-1:0] STS_SWAP = 2'd1;  // found in a swap slot
  localparam logic [STATUS_W-1:0] STS_MISS = 2'd2;  // not found / bad swap slot

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK,
    ST_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the input beat
    logic exec;     // command executed in decode (mark, load, look up, bad swap)
    logic skip;     // second chance: clear used bit, advance hand
    logic take;     // victim found: exchange tags, advance hand
    logic publish;  // move result into the output register
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic swap_go;      // captured command is a swap in with a valid swap slot
    logic victim_here;  // owner under the hand has a clear used bit
    logic out_free;     // output register empty or being drained
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cssr_ctrl.sv =====
`default_nettype none

module cssr_ctrl
  import cssr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output ctl_t         ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        state_next = sts.swap_go ? ST_WALK : ST_FINISH;
      end
      ST_WALK: begin
        if (sts.victim_here) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      ST_DECODE: begin
        ctl.exec = !sts.swap_go;
      end
      ST_WALK: begin
        ctl.take = sts.victim_here;
        ctl.skip = !sts.victim_here;
      end
      ST_FINISH: begin
        ctl.publish = sts.out_free;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // a walk only starts from a decoded swap in
  a_walk_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && $past(state) != ST_WALK) |-> $past(sts.swap_go))
    else $error("walk entered without a valid swap in");

  // a new beat is never taken while an item is in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |=> !in_ready)
    else $error("input ready while item in flight");

  // at most one datapath command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ctl))
    else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/cssr_datapath.sv =====
`default_nettype none

module cssr_datapath
  import cssr_pkg::*;
#(
  parameter int RESIDENT_SLOTS = DEF_RESIDENT_SLOTS,
  parameter int SWAP_SLOTS     = DEF_SWAP_SLOTS,
  parameter int PROCESS_IDS    = DEF_PROCESS_IDS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctl_t                ctl,
  output dp_sts_t                  sts,
  input  wire logic [CMD_W-1:0]    cmd,
  input  wire logic [PID_W-1:0]    pid,
  input  wire logic [SLOT_W-1:0]   slot,
  input  wire logic [SWAP_W-1:0]   swap_slot,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      status,
  output logic [SLOT_W-1:0]        found_index,
  output logic [SLOT_W-1:0]        victim_slot,
  output logic [PID_W-1:0]         evicted_pid,
  output logic [PID_W-1:0]         incoming_pid
);

  localparam int HW = (RESIDENT_SLOTS > 1) ? $clog2(RESIDENT_SLOTS) : 1;

  // architectural state
  logic [PID_W-1:0]       res_own [RESIDENT_SLOTS];
  logic [PID_W-1:0]       swp_own [SWAP_SLOTS];
  logic [PROCESS_IDS-1:0] used;
  logic [HW-1:0]          hand;

  // captured beat
  cmd_t              cmd_q;
  logic [PID_W-1:0]  pid_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SWAP_W-1:0] sw_q;

  // pending result
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_found;
  logic [SLOT_W-1:0]   res_victim;
  logic [PID_W-1:0]    res_evicted;
  logic [PID_W-1:0]    res_incoming;

  logic [PID_W-1:0]       own_h;
  logic [PROCESS_IDS-1:0] own_mask;
  logic [PROCESS_IDS-1:0] pid_mask;
  logic [PID_W-1:0]       in_sel;
  logic                   sw_ok;
  logic [HW-1:0]          hand_adv;
  logic                   lk_res_hit;
  logic [SLOT_W-1:0]      lk_res_idx;
  logic                   lk_swp_hit;
  logic [SLOT_W-1:0]      lk_swp_idx;
  logic [STATUS_W-1:0]    ex_status;
  logic [SLOT_W-1:0]      ex_found;

  assign own_h    = res_own[hand];
  assign hand_adv = (hand == HW'(RESIDENT_SLOTS - 1)) ? '0 : hand + 1'b1;
  assign sw_ok    = int'(sw_q) < SWAP_SLOTS;

  // pids at or above PROCESS_IDS have no used bit: empty mask
  always_comb begin
    own_mask = '0;
    pid_mask = '0;
    for (int p = 0; p < PROCESS_IDS; p++) begin
      own_mask[p] = (int'(own_h) == p);
      pid_mask[p] = (int'(pid_q) == p);
    end
  end

  always_comb begin
    in_sel = '0;
    for (int j = 0; j < SWAP_SLOTS; j++) begin
      if (int'(sw_q) == j) in_sel = swp_own[j];
    end
  end

  // look up: walk downwards so the lowest match wins
  always_comb begin
    lk_res_hit = 1'b0;
    lk_res_idx = '0;
    lk_swp_hit = 1'b0;
    lk_swp_idx = '0;
    for (int i = RESIDENT_SLOTS - 1; i >= 0; i--) begin
      if (res_own[i] == pid_q) begin
        lk_res_hit = 1'b1;
        lk_res_idx = SLOT_W'(i);
      end
    end
    for (int j = SWAP_SLOTS - 1; j >= 0; j--) begin
      if (swp_own[j] == pid_q) begin
        lk_swp_hit = 1'b1;
        lk_swp_idx = SLOT_W'(j);
      end
    end
  end

  // result of a command executed in the decode step
  always_comb begin
    ex_status = STS_DONE;
    ex_found  = '0;
    if (cmd_q == CMD_LOOKUP) begin
      if (lk_res_hit) begin
        ex_found = lk_res_idx;
      end else if (lk_swp_hit) begin
        ex_status = STS_SWAP;
        ex_found  = lk_swp_idx;
      end else begin
        ex_status = STS_MISS;
      end
    end else if (cmd_q == CMD_SWAP) begin
      // only executed here with an out-of-range swap slot
      ex_status = STS_MISS;
    end
  end

  assign sts.swap_go     = (cmd_q == CMD_SWAP) && sw_ok;
  assign sts.victim_here = ~|(used & own_mask);
  assign sts.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RESIDENT_SLOTS; i++) res_own[i] <= '0;
      for (int j = 0; j < SWAP_SLOTS; j++) swp_own[j] <= '0;
      used      <= '0;
      hand      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.capture) begin
        cmd_q  <= cmd_t'(cmd);
        pid_q  <= pid;
        slot_q <= slot;
        sw_q   <= swap_slot;
      end

      if (ctl.exec) begin
        res_status   <= ex_status;
        res_found    <= ex_found;
        res_victim   <= '0;
        res_evicted  <= '0;
        res_incoming <= '0;
        unique case (cmd_q)
          CMD_MARK: begin
            used <= used | pid_mask;
          end
          CMD_LOAD: begin
            for (int i = 0; i < RESIDENT_SLOTS; i++) begin
              if (int'(slot_q) == i) res_own[i] <= pid_q;
            end
            for (int j = 0; j < SWAP_SLOTS; j++) begin
              if (int'(slot_q) == RESIDENT_SLOTS + j) swp_own[j] <= pid_q;
            end
          end
          CMD_LOOKUP, CMD_SWAP: ;
        endcase
      end

      if (ctl.skip) begin
        used <= used & ~own_mask;
        hand <= hand_adv;
      end

      if (ctl.take) begin
        for (int i = 0; i < RESIDENT_SLOTS; i++) begin
          if (int'(hand) == i) res_own[i] <= in_sel;
        end
        for (int j = 0; j < SWAP_SLOTS; j++) begin
          if (int'(sw_q) == j) swp_own[j] <= own_h;
        end
        hand         <= hand_adv;
        res_status   <= STS_DONE;
        res_found    <= '0;
        res_victim   <= SLOT_W'(hand);
        res_evicted  <= own_h;
        res_incoming <= in_sel;
      end

      if (ctl.publish) begin
        status       <= res_status;
        found_index  <= res_found;
        victim_slot  <= res_victim;
        evicted_pid  <= res_evicted;
        incoming_pid <= res_incoming;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_hand_range: assert property (@(posedge clk) disable iff (rst)
    int'(hand) < RESIDENT_SLOTS)
    else $error("clock hand out of range");

  a_take_clear: assert property (@(posedge clk) disable iff (rst)
    ctl.take |-> ~|(used & own_mask))
    else $error("victim taken with used bit set");

  a_skip_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.skip |=> ~|(used & $past(own_mask)))
    else $error("second chance did not clear used bit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.publish |-> (!out_valid || out_ready))
    else $error("result overwrote an unread beat");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/clock_stack_slot_replacer.sv =====
`default_nettype none

// Channel | signals                              | beat moves when
// --------+--------------------------------------+--------------------------
// in      | in_valid/in_ready, cmd pid slot       | in_valid & in_ready
//         | swap_slot                            |
// out     | out_valid/out_ready, status          | out_valid & out_ready
//         | found_index victim_slot evicted_pid   |
//         | incoming_pid                         |
//
// One item at a time. Mark, load, look up and a bad swap slot pass through
// idle (accept), decode and finish before the next accept.
// Swap in also walks the clock hand between decode and finish; V = slots visited, one per
// cycle, 1..RESIDENT_SLOTS+1 (up to 6 with five slots).
// The output register holds one result; a new beat is accepted while it
// waits, and the item stalls in its finish step until the register drains.
// rst (synchronous) clears tags, used bits, hand, the sequencer state and the output valid flag.

module clock_stack_slot_replacer
  import cssr_pkg::*;
#(
  parameter int RESIDENT_SLOTS = DEF_RESIDENT_SLOTS,
  parameter int SWAP_SLOTS     = DEF_SWAP_SLOTS,
  parameter int PROCESS_IDS    = DEF_PROCESS_IDS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [CMD_W-1:0]    cmd,
  input  wire logic [PID_W-1:0]    pid,
  input  wire logic [SLOT_W-1:0]   slot,
  input  wire logic [SWAP_W-1:0]   swap_slot,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      status,
  output logic [SLOT_W-1:0]        found_index,
  output logic [SLOT_W-1:0]        victim_slot,
  output logic [PID_W-1:0]         evicted_pid,
  output logic [PID_W-1:0]         incoming_pid
);

  ctl_t    ctl;  // sequencing commands
  dp_sts_t sts;  // datapath flags back to the sequencer

  // sequencer: idle -> decode -> (walk...) -> finish
  cssr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // tags, used bits, hand, result and output registers
  cssr_datapath #(
    .RESIDENT_SLOTS (RESIDENT_SLOTS),
    .SWAP_SLOTS     (SWAP_SLOTS),
    .PROCESS_IDS    (PROCESS_IDS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .cmd          (cmd),
    .pid          (pid),
    .slot         (slot),
    .swap_slot    (swap_slot),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found_index  (found_index),
    .victim_slot  (victim_slot),
    .evicted_pid  (evicted_pid),
    .incoming_pid (incoming_pid)
  );

endmodule

`default_nettype wire
